// ===== hw/rtl/abfs_pkg.sv =====
// abfs_pkg: shared types and codes for the a/b feed sequence arbiter
// used by abfs_cell and ab_feed_sequence_arbiter; depends on nothing

package abfs_pkg;

    localparam int SEQ_W = 64;
    localparam int CNT_W = 6;
    localparam int DISP_W = 3;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_SKIP   = 1'b1;

    localparam logic [DISP_W-1:0] DISP_DELIVERED = 3'd0;
    localparam logic [DISP_W-1:0] DISP_STALE_DUP = 3'd1;
    localparam logic [DISP_W-1:0] DISP_HELD_DUP  = 3'd2;
    localparam logic [DISP_W-1:0] DISP_HELD      = 3'd3;
    localparam logic [DISP_W-1:0] DISP_BEYOND    = 3'd4;
    localparam logic [DISP_W-1:0] DISP_SKIP_NONE = 3'd5;
    localparam logic [DISP_W-1:0] DISP_SKIP_REL  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             func;
        logic [SEQ_W-1:0] seq;
    } t_in_word;

    typedef struct packed {
        logic              released_valid;
        logic [SEQ_W-1:0]  released_seq;
        logic              last;
        logic [DISP_W-1:0] disposition;
        logic [SEQ_W-1:0]  next_expected;
        logic [CNT_W-1:0]  buffered_count;
        logic [SEQ_W-1:0]  duplicate_count;
        logic              gap_open;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic set;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/abfs_cell.sv =====
// abfs_cell: one occupancy bit of the reorder window
// shifts toward bit 0 from its neighbor or sets on insert; uses abfs_pkg

module abfs_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abfs_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_next,
    output logic                 o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.shift) begin
            n_bit = i_next;
        end else if (i_ctl.set) begin
            n_bit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== hw/rtl/ab_feed_sequence_arbiter.sv =====
// ab_feed_sequence_arbiter: merges two sequenced feeds, holds early packets in
// a row of abfs_cell bits and releases them in order; uses abfs_pkg
//
//  channel | valid       | stall        | word
//  input   | i_in_valid  | o_in_stall   | i_in_data  (abfs_pkg::t_in_word)
//  output  | o_out_valid | i_out_stall  | o_out_data (abfs_pkg::t_out_word)
//
// an item that releases nothing or only its own number goes from idle to emit
// a packet that drains held numbers passes through drain, then emits a word each
// a skip with held numbers walks empty cells in seek, then drains and emits
// the cell row shifts one place a cycle, which sets the drain and skip time
// reset: synchronous active low, expected number 1, window and counts clear
// an output stall holds the emit state; intake stalls until the last word loads

module ab_feed_sequence_arbiter #(
    parameter int WINDOW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  abfs_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output abfs_pkg::t_out_word  o_out_data
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int LEFT_W = $clog2(WINDOW + 2);
    localparam int SEQ_W  = abfs_pkg::SEQ_W;
    localparam int CNT_W  = abfs_pkg::CNT_W;

    abfs_pkg::t_state              r_state;
    abfs_pkg::t_state              n_state;
    logic [SEQ_W-1:0]              r_exp;
    logic [SEQ_W-1:0]              n_exp;
    logic [SEQ_W-1:0]              r_dup;
    logic [SEQ_W-1:0]              n_dup;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              n_cnt;
    logic [abfs_pkg::DISP_W-1:0]   r_disp;
    logic [abfs_pkg::DISP_W-1:0]   n_disp;
    logic [SEQ_W-1:0]              r_rel_cur;
    logic [SEQ_W-1:0]              n_rel_cur;
    logic [LEFT_W-1:0]             r_left;
    logic [LEFT_W-1:0]             n_left;
    logic                          r_ovalid;
    logic                          n_ovalid;
    abfs_pkg::t_out_word           r_odata;
    abfs_pkg::t_out_word           n_odata;

    logic [WINDOW-1:0]             w_bits;
    logic [WINDOW-1:0]             w_next;
    abfs_pkg::t_cell_ctl           w_ctl [WINDOW];

    logic                          w_acc;
    logic                          w_pkt;
    logic                          w_lt;
    logic                          w_eq;
    logic [SEQ_W-1:0]              w_d;
    logic                          w_far;
    logic [IDX_W-1:0]              w_idx;
    logic                          w_hit;
    logic                          w_any;
    logic                          w_skip_none;
    logic                          w_load;
    logic                          w_released;
    logic [SEQ_W-1:0]              w_dup_inc;
    logic                          w_shift;
    logic                          w_ins;

    // cell row
    assign w_next = {1'b0, w_bits[WINDOW-1:1]};

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        abfs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_next  (w_next[g]),
            .o_bit   (w_bits[g])
        );
    end

    // intake decode
    assign w_acc       = i_in_valid && (r_state == abfs_pkg::ST_IDLE);
    assign w_pkt       = (i_in_data.func == abfs_pkg::FUNC_PACKET);
    assign w_lt        = (i_in_data.seq < r_exp);
    assign w_eq        = (i_in_data.seq == r_exp);
    assign w_d         = i_in_data.seq - r_exp;
    assign w_far       = (w_d > SEQ_W'(WINDOW));
    assign w_idx       = IDX_W'(w_d - SEQ_W'(1));
    assign w_hit       = w_bits[w_idx];
    assign w_any       = |w_bits;
    assign w_skip_none = (r_cnt == '0) || !w_any;
    assign w_load      = (r_state == abfs_pkg::ST_EMIT) && (!r_ovalid || !i_out_stall);
    assign w_released  = (r_disp == abfs_pkg::DISP_DELIVERED)
                      || (r_disp == abfs_pkg::DISP_SKIP_REL);
    assign w_dup_inc   = (r_dup == '1) ? r_dup : r_dup + SEQ_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            abfs_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (w_pkt && w_eq && w_bits[0]) begin
                        n_state = abfs_pkg::ST_DRAIN;
                    end else if (!w_pkt && !w_skip_none) begin
                        n_state = abfs_pkg::ST_SEEK;
                    end else begin
                        n_state = abfs_pkg::ST_EMIT;
                    end
                end
            end
            abfs_pkg::ST_SEEK: begin
                if (w_bits[0]) begin
                    n_state = abfs_pkg::ST_DRAIN;
                end
            end
            abfs_pkg::ST_DRAIN: begin
                if (!w_bits[0]) begin
                    n_state = abfs_pkg::ST_EMIT;
                end
            end
            abfs_pkg::ST_EMIT: begin
                if (w_load && (r_left <= LEFT_W'(1))) begin
                    n_state = abfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = abfs_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_shift = 1'b0;
        w_ins   = 1'b0;
        case (r_state)
            abfs_pkg::ST_IDLE: begin
                w_shift = w_acc && w_pkt && w_eq && !w_bits[0];
                w_ins   = w_acc && w_pkt && !w_lt && !w_eq && !w_far && !w_hit;
            end
            abfs_pkg::ST_SEEK: begin
                w_shift = !w_bits[0];
            end
            abfs_pkg::ST_DRAIN: begin
                w_shift = 1'b1;
            end
            default: begin
                w_shift = 1'b0;
                w_ins   = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int g = 0; g < WINDOW; g++) begin
            w_ctl[g].shift = w_shift;
            w_ctl[g].set   = w_ins && (w_idx == IDX_W'(g));
        end
    end

    // datapath
    always_comb begin
        n_exp     = r_exp;
        n_dup     = r_dup;
        n_cnt     = r_cnt;
        n_disp    = r_disp;
        n_rel_cur = r_rel_cur;
        n_left    = r_left;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            abfs_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_left = '0;
                    if (w_pkt) begin
                        if (w_lt) begin
                            n_dup  = w_dup_inc;
                            n_disp = abfs_pkg::DISP_STALE_DUP;
                        end else if (w_eq) begin
                            n_disp    = abfs_pkg::DISP_DELIVERED;
                            n_rel_cur = r_exp;
                            n_left    = LEFT_W'(1);
                            n_exp     = r_exp + SEQ_W'(1);
                        end else if (w_far) begin
                            n_disp = abfs_pkg::DISP_BEYOND;
                        end else if (w_hit) begin
                            n_dup  = w_dup_inc;
                            n_disp = abfs_pkg::DISP_HELD_DUP;
                        end else begin
                            n_cnt  = r_cnt + CNT_W'(1);
                            n_disp = abfs_pkg::DISP_HELD;
                        end
                    end else if (w_skip_none) begin
                        n_disp = abfs_pkg::DISP_SKIP_NONE;
                    end else begin
                        n_disp = abfs_pkg::DISP_SKIP_REL;
                    end
                end
            end
            abfs_pkg::ST_SEEK: begin
                n_exp = r_exp + SEQ_W'(1);
                if (w_bits[0]) begin
                    n_rel_cur = r_exp + SEQ_W'(1);
                end
            end
            abfs_pkg::ST_DRAIN: begin
                if (w_bits[0]) begin
                    n_exp  = r_exp + SEQ_W'(1);
                    n_left = r_left + LEFT_W'(1);
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            abfs_pkg::ST_EMIT: begin
                if (w_load) begin
                    n_ovalid                = 1'b1;
                    n_odata.released_valid  = w_released;
                    n_odata.released_seq    = w_released ? r_rel_cur : '0;
                    n_odata.last            = (r_left <= LEFT_W'(1));
                    n_odata.disposition     = r_disp;
                    n_odata.next_expected   = r_exp;
                    n_odata.buffered_count  = r_cnt;
                    n_odata.duplicate_count = r_dup;
                    n_odata.gap_open        = (r_cnt != '0);
                    n_rel_cur               = r_rel_cur + SEQ_W'(1);
                    if (r_left != '0) begin
                        n_left = r_left - LEFT_W'(1);
                    end
                end
            end
            default: begin
                n_left = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= abfs_pkg::ST_IDLE;
            r_exp    <= SEQ_W'(1);
            r_dup    <= '0;
            r_cnt    <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_exp    <= n_exp;
            r_dup    <= n_dup;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disp    <= n_disp;
        r_rel_cur <= n_rel_cur;
        r_odata   <= n_odata;
    end

    assign o_in_stall  = (r_state != abfs_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef NO_ASSERTIONS
    a_count_matches_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abfs_pkg::ST_IDLE) |-> (32'(r_cnt) == 32'($countones(w_bits))))
        else $error("held count disagrees with occupied cells");

    a_seek_has_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abfs_pkg::ST_SEEK) |-> w_any)
        else $error("skip walk with an empty window");

    a_idle_holds_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abfs_pkg::ST_IDLE && !w_acc) |=> $stable(r_exp))
        else $error("expected number moved without an item");

    a_release_disposition: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.released_valid) |->
        (o_out_data.disposition == abfs_pkg::DISP_DELIVERED
         || o_out_data.disposition == abfs_pkg::DISP_SKIP_REL))
        else $error("released word with a non-release disposition");
`endif

endmodule
